// ===== sv/mclw_pkg.sv =====
// ----------------------------------------------------------------------------
// mclw_pkg
// Shared types and codes of the multi-channel liveness watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package mclw_pkg;

    // Event opcodes.
    localparam logic [3:0] OP_INIT    = 4'd0;
    localparam logic [3:0] OP_BEAT    = 4'd1;
    localparam logic [3:0] OP_PROG    = 4'd2;
    localparam logic [3:0] OP_REPORT  = 4'd3;
    localparam logic [3:0] OP_DONE    = 4'd4;
    localparam logic [3:0] OP_ALIVE   = 4'd5;
    localparam logic [3:0] OP_EXITED  = 4'd6;
    localparam logic [3:0] OP_RESPAWN = 4'd7;
    localparam logic [3:0] OP_SWEEP   = 4'd8;

    // Stall codes.
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_DEADLINE = 3'd1;
    localparam logic [2:0] ST_NOPROG   = 3'd2;
    localparam logic [2:0] ST_CHILD    = 3'd3;
    localparam logic [2:0] ST_REPEAT   = 3'd4;

    // Worker states.
    localparam logic [1:0] WK_UNKNOWN    = 2'd0;
    localparam logic [1:0] WK_ALIVE      = 2'd1;
    localparam logic [1:0] WK_EXITED     = 2'd2;
    localparam logic [1:0] WK_RESTARTING = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TICK    = 3'd0;
    localparam logic [2:0] CFG_DEADL   = 3'd1;
    localparam logic [2:0] CFG_QUIET   = 3'd2;
    localparam logic [2:0] CFG_RSTEN   = 3'd3;
    localparam logic [2:0] CFG_CAP     = 3'd4;
    localparam logic [2:0] CFG_WINDOW  = 3'd5;

    localparam int NOW_W = 48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/mclw_if.sv =====
// ----------------------------------------------------------------------------
// mclw_if
// Event, result and configuration channels of the watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

interface mclw_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [3:0]  channel;
    logic [47:0] now_us;
    logic signed [63:0] marker;
    logic [2:0]  reason;
    logic        respawn_ok;

    modport source (output valid, opcode, channel, now_us, marker, reason, respawn_ok,
                    input ready);
    modport sink (input valid, opcode, channel, now_us, marker, reason, respawn_ok,
                  output ready);
endinterface

interface mclw_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_out;
    logic        status;
    logic        tick_due;
    logic        respawn_request;
    logic        stall_fired;
    logic [2:0]  stall_code;
    logic [1:0]  worker_state_out;
    logic [31:0] restart_total;
    logic [31:0] heartbeat_total;

    modport source (output valid, channel_out, status, tick_due, respawn_request,
                    stall_fired, stall_code, worker_state_out, restart_total,
                    heartbeat_total, input ready);
    modport sink (input valid, channel_out, status, tick_due, respawn_request,
                  stall_fired, stall_code, worker_state_out, restart_total,
                  heartbeat_total, output ready);
endinterface

interface mclw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/mclw_ram.sv =====
// ----------------------------------------------------------------------------
// mclw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mclw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic                                          re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// ===== sv/mclw_ctrl.sv =====
// ----------------------------------------------------------------------------
// mclw_ctrl
// Controller: sequences read and update of one channel entry per event and
// owns the event and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mclw_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          evt_valid,
    output logic               evt_ready,
    output logic               res_valid,
    input  wire logic          res_ready,
    output mclw_pkg::cmd_t     cmd
);
    typedef enum logic {IDLE, EXEC} state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;

    // Accept only when idle and the result register is free by the next edge.
    assign evt_ready   = (state_reg == IDLE) && (!res_valid_reg || res_ready);
    assign cmd.capture = evt_valid && evt_ready;
    assign cmd.exec    = (state_reg == EXEC);
    assign res_valid   = res_valid_reg;

    // Next state and result valid.
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                state_next     = IDLE;
                res_valid_next = 1'b1;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end
endmodule

`default_nettype wire

// ===== sv/mclw_dpath.sv =====
// ----------------------------------------------------------------------------
// mclw_dpath
// Datapath: configuration registers, channel table, per-event update logic
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mclw_dpath #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mclw_pkg::cmd_t cmd,
    mclw_evt_if.sink            evt,
    mclw_cfg_if.sink            cfg,
    mclw_res_if.source          res
);
    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TB    = TIME_BITS;
    localparam int REC_W = 3 * TB + 142;
    localparam logic [8:0] CH_LIM = 9'(CHANNELS);

    // Configuration registers.
    logic [31:0] tick_reg, deadl_reg, quiet_reg, window_reg;
    logic        rsten_reg;
    logic [7:0]  cap_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            deadl_reg  <= '0;
            quiet_reg  <= '0;
            rsten_reg  <= 1'b0;
            cap_reg    <= 8'd1;
            window_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mclw_pkg::CFG_TICK:   tick_reg   <= cfg.data;
                mclw_pkg::CFG_DEADL:  deadl_reg  <= cfg.data;
                mclw_pkg::CFG_QUIET:  quiet_reg  <= cfg.data;
                mclw_pkg::CFG_RSTEN:  rsten_reg  <= cfg.data[0];
                mclw_pkg::CFG_CAP:    cap_reg    <= cfg.data[7:0];
                mclw_pkg::CFG_WINDOW: window_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Captured event.
    logic [3:0]  op_q, chan_q;
    logic [47:0] now_q;
    logic [63:0] marker_q;
    logic [2:0]  reason_q;
    logic        ok_q;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_q     <= evt.opcode;
            chan_q   <= evt.channel;
            now_q    <= evt.now_us;
            marker_q <= evt.marker;
            reason_q <= evt.reason;
            ok_q     <= evt.respawn_ok;
        end
    end

    // Channel table: valid bits in flops, the rest of the entry in RAM.
    logic [CHANNELS-1:0] chv_reg;
    logic [REC_W-1:0]    rd_data, wr_data;
    logic                we;
    logic [AW-1:0]       idx;

    assign idx = AW'(chan_q);

    mclw_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (idx),
        .wdata (wr_data),
        .re    (cmd.capture),
        .raddr (AW'(evt.channel)),
        .rdata (rd_data)
    );

    logic          r_done, n_done;
    logic [TB-1:0] r_lbt, n_lbt, r_ptm, n_ptm, r_wst, n_wst;
    logic [63:0]   r_pval, n_pval;
    logic [2:0]    r_stl, n_stl;
    logic [1:0]    r_wk, n_wk;
    logic [7:0]    r_wr, n_wr, wr_eff, cap_eff;
    logic [31:0]   r_rc, n_rc, r_bc, n_bc;

    assign {r_done, r_lbt, r_pval, r_ptm, r_stl, r_wk, r_wst, r_wr, r_rc, r_bc} = rd_data;
    assign wr_data = {n_done, n_lbt, n_pval, n_ptm, n_stl, n_wk, n_wst, n_wr, n_rc, n_bc};

    logic          in_range, valid, live, handled, set_valid;
    logic          tick, resp, fired;
    logic [2:0]    code;
    logic [TB-1:0] now_t, el_beat, el_prog, el_win;

    assign in_range = (9'(chan_q) < CH_LIM);
    assign valid    = in_range && chv_reg[idx];
    assign live     = valid && !r_done;
    assign now_t    = TB'(now_q);
    assign el_beat  = now_t - r_lbt;
    assign el_prog  = now_t - r_ptm;
    assign el_win   = now_t - r_wst;
    assign cap_eff  = (cap_reg == 8'd0) ? 8'd1 : cap_reg;

    // Entry update and result for the captured event.
    always_comb
    begin
        n_done = r_done; n_lbt = r_lbt; n_pval = r_pval; n_ptm = r_ptm;
        n_stl = r_stl; n_wk = r_wk; n_wst = r_wst; n_wr = r_wr;
        n_rc = r_rc; n_bc = r_bc;
        wr_eff = r_wr;
        tick = 1'b0; resp = 1'b0; fired = 1'b0; code = mclw_pkg::ST_NONE;
        handled = 1'b0; set_valid = 1'b0;
        case (op_q)
            mclw_pkg::OP_INIT:
            begin
                if (in_range)
                begin
                    handled = 1'b1; set_valid = 1'b1;
                    n_done = 1'b0; n_lbt = now_t; n_ptm = now_t; n_wst = now_t;
                    n_pval = '0; n_stl = mclw_pkg::ST_NONE;
                    n_wk = mclw_pkg::WK_UNKNOWN; n_wr = '0; n_rc = '0; n_bc = '0;
                end
            end
            mclw_pkg::OP_BEAT:
            begin
                if (live)
                begin
                    handled = 1'b1;
                    n_lbt = now_t;
                    n_bc  = r_bc + 32'd1;
                    if (r_stl == mclw_pkg::ST_DEADLINE || r_stl == mclw_pkg::ST_CHILD)
                    begin
                        n_stl = mclw_pkg::ST_NONE;
                    end
                end
            end
            mclw_pkg::OP_PROG:
            begin
                if (live)
                begin
                    handled = 1'b1;
                    if (marker_q != r_pval)
                    begin
                        n_pval = marker_q;
                        n_ptm  = now_t;
                        if (r_stl == mclw_pkg::ST_NOPROG)
                        begin
                            n_stl = mclw_pkg::ST_NONE;
                        end
                    end
                end
            end
            mclw_pkg::OP_REPORT:
            begin
                if (live)
                begin
                    handled = 1'b1;
                    if (reason_q inside {[3'd1:3'd4]} && r_stl == mclw_pkg::ST_NONE)
                    begin
                        n_stl = reason_q; fired = 1'b1; code = reason_q;
                    end
                end
            end
            mclw_pkg::OP_DONE:
            begin
                if (live)
                begin
                    handled = 1'b1;
                    n_stl = mclw_pkg::ST_NONE; n_lbt = now_t; n_done = 1'b1;
                end
            end
            mclw_pkg::OP_ALIVE, mclw_pkg::OP_EXITED:
            begin
                if (valid)
                begin
                    handled = 1'b1;
                    n_wk = (op_q == mclw_pkg::OP_ALIVE) ? mclw_pkg::WK_ALIVE
                                                        : mclw_pkg::WK_EXITED;
                end
            end
            mclw_pkg::OP_RESPAWN:
            begin
                if (valid)
                begin
                    handled = 1'b1;
                    if (r_wk == mclw_pkg::WK_RESTARTING)
                    begin
                        if (ok_q)
                        begin
                            if (r_wr != 8'hFF)
                            begin
                                n_wr = r_wr + 8'd1;
                            end
                            n_rc = r_rc + 32'd1;
                        end
                        else
                        begin
                            n_wk = mclw_pkg::WK_EXITED;
                        end
                    end
                end
            end
            mclw_pkg::OP_SWEEP:
            begin
                if (live)
                begin
                    handled = 1'b1;
                    // Periodic tick.
                    if (tick_reg != '0 && el_beat >= TB'(tick_reg))
                    begin
                        tick = 1'b1; n_lbt = now_t; n_bc = r_bc + 32'd1;
                    end
                    // Bounded restart policy with window roll.
                    if (rsten_reg && r_wk == mclw_pkg::WK_EXITED &&
                        r_stl != mclw_pkg::ST_REPEAT)
                    begin
                        if (window_reg != '0 && el_win > TB'(window_reg))
                        begin
                            n_wst = now_t; n_wr = '0; wr_eff = '0;
                        end
                        if (wr_eff >= cap_eff)
                        begin
                            if (r_stl == mclw_pkg::ST_NONE)
                            begin
                                n_stl = mclw_pkg::ST_REPEAT; fired = 1'b1;
                                code = mclw_pkg::ST_REPEAT;
                            end
                        end
                        else
                        begin
                            n_wk = mclw_pkg::WK_RESTARTING; resp = 1'b1;
                        end
                    end
                    // Deadline and no-progress stalls; a fresh tick restamps the beat.
                    if (n_stl == mclw_pkg::ST_NONE)
                    begin
                        if (deadl_reg != '0 && !tick && el_beat >= TB'(deadl_reg))
                        begin
                            n_stl = mclw_pkg::ST_DEADLINE; fired = 1'b1;
                            code = mclw_pkg::ST_DEADLINE;
                        end
                        else if (quiet_reg != '0 && el_prog >= TB'(quiet_reg))
                        begin
                            n_stl = mclw_pkg::ST_NOPROG; fired = 1'b1;
                            code = mclw_pkg::ST_NOPROG;
                        end
                    end
                end
            end
            default: ;
        endcase
        we = cmd.exec && handled;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chv_reg <= '0;
        end
        else if (cmd.exec && set_valid)
        begin
            chv_reg[idx] <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res.channel_out      <= chan_q;
            res.status           <= !handled;
            res.tick_due         <= handled && tick;
            res.respawn_request  <= handled && resp;
            res.stall_fired      <= handled && fired;
            res.stall_code       <= handled ? code : mclw_pkg::ST_NONE;
            res.worker_state_out <= handled ? n_wk : mclw_pkg::WK_UNKNOWN;
            res.restart_total    <= handled ? n_rc : 32'd0;
            res.heartbeat_total  <= handled ? n_bc : 32'd0;
        end
    end
endmodule

`default_nettype wire

// ===== sv/multi_channel_liveness_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_liveness_watchdog
// Per-channel liveness watchdog with tick, restart policy and stall detection.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake     Contents
//  evt      in         valid/ready   opcode, channel, now_us, marker, reason, ok
//  res      out        valid/ready   one result per event
//  cfg      in         valid/ready   register index and 32-bit write data
//
//  Each event is handled in two steps: the channel entry is read from the
//  table RAM, then it is computed, written back and the result register loaded.
//  The table RAM's single read and write port sets these two steps.
//  Events are held off while a result waits and cannot be replaced in time.
//  Reset initialises the config registers, valid bits and handshake state; no
//  clearing pass runs. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_liveness_watchdog #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mclw_evt_if.sink   evt,
    mclw_res_if.source res,
    mclw_cfg_if.sink   cfg
);
    mclw_pkg::cmd_t cmd;

    mclw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd)
    );

    mclw_dpath #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .evt   (evt),
        .cfg   (cfg),
        .res   (res)
    );

    // An accepted event yields its result once the EXEC state has loaded it.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready) |=> ##1 res.valid)
        else $error("result did not follow an accepted event");

    // No second event while one is in work.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready) |=> !evt.ready)
        else $error("event accepted while busy");

    // A fired stall carries a code.
    a_fired_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.stall_fired) |-> (res.stall_code != mclw_pkg::ST_NONE))
        else $error("stall fired without a code");

    // An ignored event reports nothing else.
    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |->
            (!res.tick_due && !res.respawn_request && !res.stall_fired))
        else $error("ignored event reported activity");
endmodule

`default_nettype wire
